// ===== rtl/linear_level_fader_macros.svh =====
// Assertion macros shared by the checker
`ifndef LINEAR_LEVEL_FADER_MACROS_SVH
`define LINEAR_LEVEL_FADER_MACROS_SVH

// Checked only while out of reset
`define LLF_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define LLF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/llf_pkg.sv =====
package llf_pkg;

    localparam int LEVEL_W     = 16;
    localparam int DUTY_W      = 8;
    localparam int FADE_TIME_W = 24;
    localparam int TIME_W_DEF  = 24;

    // quotient always fits the level width, one bit per divider step
    localparam int DIV_STEPS = LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;      // capture transaction, advance elapsed on a tick
        logic mul;       // elapsed * distance into the divider
        logic div_step;  // one restoring-division step
        logic finish;    // update fade state, write result
    } t_cmd;

    typedef struct packed {
        logic out_free;  // result register can take a new result
    } t_stat;

endpackage

// ===== rtl/llf_ctrl.sv =====
module llf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  llf_pkg::t_stat i_stat,
    output llf_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [llf_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [llf_pkg::DIV_CNT_W-1:0]  n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == llf_pkg::DIV_CNT_W'(llf_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/llf_datapath.sv =====
module llf_datapath #(
    parameter int TIME_WIDTH = llf_pkg::TIME_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  llf_pkg::t_cmd                    i_cmd,
    output llf_pkg::t_stat                   o_stat,
    input  logic                             i_action,
    input  logic [llf_pkg::LEVEL_W-1:0]      i_target_level,
    input  logic [llf_pkg::FADE_TIME_W-1:0]  i_fade_time,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [llf_pkg::LEVEL_W-1:0]      o_level_out,
    output logic [llf_pkg::DUTY_W-1:0]       o_pwm_duty,
    output logic                             o_fade_done
);

    localparam int LW     = llf_pkg::LEVEL_W;
    localparam int PROD_W = TIME_WIDTH + LW;

    // fade state
    logic [LW-1:0]         r_start;
    logic [LW-1:0]         r_goal;
    logic [TIME_WIDTH-1:0] r_len;
    logic [TIME_WIDTH-1:0] r_elapsed;

    // captured transaction
    logic                  r_goto;
    logic [LW-1:0]         r_tgt;
    logic [TIME_WIDTH-1:0] r_ft;

    // divider: remainder and shared dividend-low / quotient register
    logic [TIME_WIDTH-1:0] r_rem;
    logic [LW-1:0]         r_quo;

    logic                  r_out_valid;
    logic [LW-1:0]         r_out_level;
    logic                  r_out_done;

    logic [LW-1:0]         lvl_span;
    logic [PROD_W-1:0]     prod;
    logic [TIME_WIDTH:0]   shifted;
    logic [TIME_WIDTH:0]   len_ext;
    logic                  cur_eq;
    logic                  cur_act;
    logic                  done1;
    logic [LW-1:0]         lvl1;
    logic [LW-1:0]         n_start;
    logic [LW-1:0]         res_level;
    logic                  res_done;

    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign lvl_span = (r_goal > r_start) ? (r_goal - r_start) : (r_start - r_goal);
    assign prod     = PROD_W'(r_elapsed) * PROD_W'(lvl_span);
    assign shifted  = {r_rem, r_quo[LW-1]};
    assign len_ext  = {1'b0, r_len};

    // level seen before the transaction takes effect; r_quo holds the step
    always_comb begin
        cur_eq  = (r_goal == r_start);
        cur_act = (r_elapsed < r_len);
        done1   = !cur_eq && !cur_act;
        if (cur_eq || !cur_act) begin
            lvl1 = r_goal;
        end else if (r_goal > r_start) begin
            lvl1 = r_start + r_quo;
        end else begin
            lvl1 = r_start - r_quo;
        end
    end

    always_comb begin
        res_done  = done1;
        res_level = lvl1;
        n_start   = done1 ? r_goal : r_start;
        if (r_goto) begin
            n_start = lvl1;
            if (r_tgt == lvl1) begin
                res_level = r_tgt;
            end else if (r_ft == '0) begin
                // zero fade time jumps straight to the target
                res_level = r_tgt;
                res_done  = 1'b1;
                n_start   = r_tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_goal    <= '0;
            r_len     <= '0;
            r_elapsed <= '0;
        end else if (i_cmd.load && !i_action) begin
            r_elapsed <= (r_elapsed < r_len) ? r_elapsed + 1'b1 : r_len;
        end else if (i_cmd.finish) begin
            r_start <= n_start;
            if (r_goto) begin
                r_goal    <= r_tgt;
                r_len     <= r_ft;
                r_elapsed <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_goto <= i_action;
            r_tgt  <= i_target_level;
            r_ft   <= TIME_WIDTH'(i_fade_time);
        end
        if (i_cmd.mul) begin
            // product / len < 2^LW, so the upper part is already below len
            r_rem <= prod[PROD_W-1:LW];
            r_quo <= prod[LW-1:0];
        end else if (i_cmd.div_step) begin
            if (shifted >= len_ext) begin
                r_rem <= TIME_WIDTH'(shifted - len_ext);
                r_quo <= {r_quo[LW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[TIME_WIDTH-1:0];
                r_quo <= {r_quo[LW-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out_level <= res_level;
            r_out_done  <= res_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_level_out = r_out_level;
    assign o_pwm_duty  = r_out_level[LW-1:LW-llf_pkg::DUTY_W];
    assign o_fade_done = r_out_done;

endmodule

// ===== rtl/linear_level_fader.sv =====
// Linear dimmer level fader. Each input transaction is a tick (action 0) or a goto
// (action 1) with a new target level and fade time; each gives exactly one result:
// the 16-bit level, its upper byte as pwm duty, and a one-shot flag on the
// transaction where a fade reaches its target. After acceptance an item passes
// through a capture step, the elapsed-times-distance multiply, the bit-serial
// restoring divider that forms the interpolation step, and a final step that
// updates the fade state and loads the result register; only then can the next
// be accepted. o_stall stays high from the multiply through the final step;
// a result waiting in the result register does not hold off the next
// transaction, only its final step. TIME_WIDTH sets the elapsed and length
// counter width; fade_time is truncated or zero-extended to it.
module linear_level_fader #(
    parameter int TIME_WIDTH = llf_pkg::TIME_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_action,
    input  logic [llf_pkg::LEVEL_W-1:0]      i_target_level,
    input  logic [llf_pkg::FADE_TIME_W-1:0]  i_fade_time,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [llf_pkg::LEVEL_W-1:0]      o_level_out,
    output logic [llf_pkg::DUTY_W-1:0]       o_pwm_duty,
    output logic                             o_fade_done
);

    llf_pkg::t_cmd  cmd;
    llf_pkg::t_stat stat;

    llf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    llf_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_action),
        .i_target_level (i_target_level),
        .i_fade_time    (i_fade_time),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_level_out    (o_level_out),
        .o_pwm_duty     (o_pwm_duty),
        .o_fade_done    (o_fade_done)
    );

endmodule

// ===== rtl/llf_checker.sv =====
`include "linear_level_fader_macros.svh"

module llf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [llf_pkg::LEVEL_W-1:0]      o_level_out,
    input logic [llf_pkg::DUTY_W-1:0]       o_pwm_duty,
    input logic                             o_fade_done
);

    // one transaction in flight: busy right after every accept
    `LLF_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "accept not followed by busy")

    // duty is the upper byte of the level
    `LLF_ASSERT(a_duty_matches, i_clk, i_rst_n, o_valid |-> (o_pwm_duty == o_level_out[15:8]), "pwm duty does not track level")

    // a stalled result holds
    `LLF_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_level_out) && $stable(o_fade_done)), "stalled result changed")

    // nothing pending out of reset
    `LLF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_valid && !o_stall), "result or busy after reset")

endmodule

bind linear_level_fader llf_checker u_llf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_level_out (o_level_out),
    .o_pwm_duty  (o_pwm_duty),
    .o_fade_done (o_fade_done)
);
